[sv/srrip_dbr_pkg.sv]
package srrip_dbr_pkg;

  // The set count is taken to be a power of two, so that the set index wraps
  // onto its low bits.
  localparam int NUM_SETS = 2048;
  localparam int NUM_WAYS = 16;
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  localparam logic [3:0] COUNT_MAX      = 4'd15;
  localparam logic [3:0] STREAM_LIMIT   = 4'd8;
  localparam logic [1:0] RRPV_DISTANT   = 2'd3;
  localparam logic [1:0] RRPV_LONG      = 2'd2;
  localparam logic [1:0] RRPV_NEAR      = 2'd0;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [15:0]                last_addr;
    logic [15:0]                last_stride;
    logic [3:0]                 count;
    logic                       streaming;
    logic [NUM_WAYS-1:0]        dead;
    logic [NUM_WAYS-1:0][1:0]   rrpv;
  } set_row_t;

endpackage

[sv/srrip_dead_block_stream_replacement.sv]
// SRRIP replacement with dead-line preference and a stride detector per set.
// Requests arrive on the s_ channel: tuser carries the operation (victim
// query or update), tdata the set, way, low address bits and hit flag.
// Every request yields exactly one response on the m_ channel, carrying the
// victim way (zero for updates) and the streaming flag of the set.
// All state of a set sits in one row of a synchronous memory. A request's row
// is read into a register when the request is taken, then modified and
// written back from the execute state, and its response is registered at that
// write. A new request is not taken until the row of the last one has been
// written back.
// After reset the block sweeps the memory once, one set per cycle, to load
// the reset values; during the sweep s_tready_o stays low. When the receiver
// stalls, one response waits in the output register while the next request is
// still taken and read; that request then holds its write-back until the
// output register is free.
module srrip_dead_block_stream_replacement (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  // set_index [10:0], way_index [14:11], address_low [30:15], was_hit [31]
  input  logic [31:0] s_tdata_i,
  // operation [0]
  input  logic        s_tuser_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  // victim_way [3:0], set_streaming [4], zero [7:5]
  output logic [7:0]  m_tdata_o
);

  localparam int SetW = srrip_dbr_pkg::SET_W;
  localparam int Ways = srrip_dbr_pkg::NUM_WAYS;

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC} state_e;

  state_e                 state_q;
  logic [SetW-1:0]        clr_addr_q;
  logic                   m_tvalid_q;
  logic [7:0]             m_tdata_q;

  logic                   op_q;
  logic [SetW-1:0]        set_q;
  logic [3:0]             way_q;
  logic [15:0]            addr_q;
  logic                   hit_q;

  srrip_dbr_pkg::set_row_t mem_q [srrip_dbr_pkg::NUM_SETS];
  srrip_dbr_pkg::set_row_t rdata_q;
  srrip_dbr_pkg::set_row_t row_d;
  srrip_dbr_pkg::set_row_t rst_row;
  srrip_dbr_pkg::set_row_t wdata;

  logic                   s_accept;
  logic                   item_we;
  logic                   mem_we;
  logic [SetW-1:0]        waddr;
  logic [SetW-1:0]        s_set;
  logic [3:0]             victim;
  logic                   stream_out;

  assign s_set      = SetW'(s_tdata_i[10:0]);
  assign s_tready_o = (state_q == ST_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign item_we    = (state_q == ST_EXEC) && (!m_tvalid_q || m_tready_i);
  assign mem_we     = item_we || (state_q == ST_CLEAR);
  assign waddr      = (state_q == ST_CLEAR) ? clr_addr_q : set_q;
  assign wdata      = (state_q == ST_CLEAR) ? rst_row : row_d;
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

  always_comb begin
    rst_row             = '0;
    for (int w = 0; w < Ways; w++) begin
      rst_row.rrpv[w] = srrip_dbr_pkg::RRPV_LONG;
    end
  end

  always_comb begin
    logic                  dead_any;
    logic                  has3;
    logic                  has2;
    logic                  has1;
    logic [1:0]            add;
    logic [2:0]            sum;
    logic [Ways-1:0][1:0]  aged;
    logic [15:0]           stride;
    logic [3:0]            cnt;
    logic                  strm;
    row_d      = rdata_q;
    victim     = '0;
    stream_out = rdata_q.streaming;
    dead_any   = 1'b0;
    has3       = 1'b0;
    has2       = 1'b0;
    has1       = 1'b0;
    add        = '0;
    sum        = '0;
    aged       = rdata_q.rrpv;
    stride     = addr_q - rdata_q.last_addr;
    cnt        = rdata_q.count;
    strm       = rdata_q.streaming;
    if (op_q == srrip_dbr_pkg::OP_VICTIM) begin
      for (int w = Ways - 1; w >= 0; w--) begin
        if (rdata_q.dead[w]) begin
          dead_any = 1'b1;
          victim   = 4'(w);
        end
      end
      for (int w = 0; w < Ways; w++) begin
        has3 = has3 || (rdata_q.rrpv[w] == 2'd3);
        has2 = has2 || (rdata_q.rrpv[w] == 2'd2);
        has1 = has1 || (rdata_q.rrpv[w] == 2'd1);
      end
      add = has3 ? 2'd0 : (has2 ? 2'd1 : (has1 ? 2'd2 : 2'd3));
      for (int w = 0; w < Ways; w++) begin
        sum     = {1'b0, rdata_q.rrpv[w]} + {1'b0, add};
        aged[w] = (sum > 3'd3) ? srrip_dbr_pkg::RRPV_DISTANT : sum[1:0];
      end
      if (!dead_any) begin
        row_d.rrpv = aged;
        for (int w = Ways - 1; w >= 0; w--) begin
          if (aged[w] == srrip_dbr_pkg::RRPV_DISTANT) begin
            victim = 4'(w);
          end
        end
      end
    end else begin
      if (stride == rdata_q.last_stride) begin
        if (cnt != srrip_dbr_pkg::COUNT_MAX) begin
          cnt = cnt + 4'd1;
        end
      end else if (cnt != 4'd0) begin
        cnt = cnt - 4'd1;
      end
      strm              = (cnt >= srrip_dbr_pkg::STREAM_LIMIT);
      row_d.count       = cnt;
      row_d.streaming   = strm;
      row_d.last_addr   = addr_q;
      row_d.last_stride = stride;
      stream_out        = strm;
      for (int w = 0; w < Ways; w++) begin
        if (32'(way_q) == w) begin
          if (hit_q) begin
            row_d.dead[w] = 1'b0;
            row_d.rrpv[w] = srrip_dbr_pkg::RRPV_NEAR;
          end else begin
            if (rdata_q.dead[w]) begin
              row_d.rrpv[w] = strm ? srrip_dbr_pkg::RRPV_DISTANT
                                   : srrip_dbr_pkg::RRPV_LONG;
            end else begin
              row_d.rrpv[w] = srrip_dbr_pkg::RRPV_NEAR;
            end
            row_d.dead[w] = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (s_accept) begin
      rdata_q <= mem_q[s_set];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q   <= s_tuser_i;
      set_q  <= s_set;
      way_q  <= s_tdata_i[14:11];
      addr_q <= s_tdata_i[30:15];
      hit_q  <= s_tdata_i[31];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      if (m_tvalid_q && m_tready_i && !item_we) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_addr_q <= clr_addr_q + SetW'(1);
          if (clr_addr_q == SetW'(srrip_dbr_pkg::NUM_SETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (item_we) begin
            m_tvalid_q <= 1'b1;
            m_tdata_q  <= {3'b000, stream_out, victim};
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == ST_EXEC))
    else $error("accepted request did not move to execution");

  a_resp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_q) |-> $past(state_q == ST_EXEC))
    else $error("response raised outside execution");

  a_no_accept_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(item_we && s_accept))
    else $error("request accepted while a row is written back");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!s_tready_o && !item_we))
    else $error("request activity during the clearing sweep");

endmodule
